// ===== src/bvph_pkg.sv =====
// Package for the battery voltage peak-hold filter.
// Holds register codes, reset values, widths and the shared types.
// No dependencies.
package bvph_pkg;

    // Default sample width
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Configuration register widths and port layout
    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH    = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_MIN_REPEATS = 8'd1;

    // Configuration reset values
    localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RESET    = 16'd600;
    localparam logic [CFG_BITS-1:0] PEAK_MIN_REPEATS_RESET = 16'd120;

    // Tick counter and repeat counter widths
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] REPEAT_MAX = 16'hFFFF;

    // Result queue depth and its pointer/count widths
    localparam int QUEUE_DEPTH      = 3;
    localparam int QUEUE_PTR_BITS   = 2;
    localparam int QUEUE_COUNT_BITS = 2;

    // Configuration as seen by the filter stage
    typedef struct packed {
        logic [CFG_BITS-1:0] window_length;
        logic [CFG_BITS-1:0] peak_min_repeats;
    } bvph_cfg_t;

    // Filter stage status
    typedef struct packed {
        logic stage_valid;
        logic push;
    } bvph_core_status_t;

    // Result queue status
    typedef struct packed {
        logic [QUEUE_COUNT_BITS-1:0] count;
        logic                        pop;
    } bvph_queue_status_t;

endpackage

// ===== src/bvph_core.sv =====
// Filter stage: input register, window tracking state and result computation.
// Depends on bvph_pkg.
module bvph_core
    import bvph_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  bvph_cfg_t              cfg,
    output bvph_core_status_t      status,
    output logic [SAMPLE_BITS-1:0] result
);

    logic                   stage_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    logic [COUNT_BITS-1:0]  tick_count_reg, tick_count_next;
    logic [SAMPLE_BITS-1:0] peak_value_reg, peak_value_next;
    logic [SAMPLE_BITS-1:0] runner_up_reg, runner_up_next;
    logic [COUNT_BITS-1:0]  peak_repeats_reg, peak_repeats_next;
    logic [SAMPLE_BITS-1:0] held_value_reg, held_value_next;

    // Capture the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
    end

    // Track the window or make the decision
    always_comb
    begin
        tick_count_next   = tick_count_reg;
        peak_value_next   = peak_value_reg;
        runner_up_next    = runner_up_reg;
        peak_repeats_next = peak_repeats_reg;
        held_value_next   = held_value_reg;
        if (tick_count_reg < cfg.window_length)
        begin
            tick_count_next = tick_count_reg + COUNT_BITS'(1);
            if (sample_reg > peak_value_reg)
            begin
                runner_up_next    = peak_value_reg;
                peak_value_next   = sample_reg;
                peak_repeats_next = '0;
            end
            else if (sample_reg == peak_value_reg)
            begin
                if (peak_repeats_reg != REPEAT_MAX)
                begin
                    peak_repeats_next = peak_repeats_reg + COUNT_BITS'(1);
                end
            end
        end
        else
        begin
            if (peak_repeats_reg >= cfg.peak_min_repeats)
            begin
                held_value_next = peak_value_reg;
            end
            else if (runner_up_reg != '0)
            begin
                held_value_next = runner_up_reg;
            end
            tick_count_next   = '0;
            peak_value_next   = '0;
            runner_up_next    = '0;
            peak_repeats_next = '0;
        end
    end

    // Advance the state once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            peak_value_reg   <= '0;
            runner_up_reg    <= '0;
            peak_repeats_reg <= '0;
            held_value_reg   <= '0;
        end
        else if (stage_valid_reg)
        begin
            tick_count_reg   <= tick_count_next;
            peak_value_reg   <= peak_value_next;
            runner_up_reg    <= runner_up_next;
            peak_repeats_reg <= peak_repeats_next;
            held_value_reg   <= held_value_next;
        end
    end

    // Output the held value, or pass the sample while nothing is held
    assign result = (held_value_next != '0) ? held_value_next : sample_reg;

    assign status.stage_valid = stage_valid_reg;
    assign status.push        = stage_valid_reg;

endmodule

// ===== src/bvph_queue.sv =====
// Result queue: three-entry buffer between the filter stage and the output.
// Depends on bvph_pkg.
module bvph_queue
    import bvph_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [SAMPLE_BITS-1:0] push_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] out_data,
    output bvph_queue_status_t     status
);

    logic [SAMPLE_BITS-1:0]      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_COUNT_BITS-1:0] count_reg, count_next;
    logic                        pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_COUNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign status.count = count_reg;
    assign status.pop   = pop;

endmodule

// ===== src/battery_voltage_peak_hold_filter_core.sv =====
// Top level of the battery voltage peak-hold filter.
// Depends on bvph_pkg, bvph_core and bvph_queue.
//
//  Channel  Direction  Handshake             Payload
//  in       to block   in_valid / in_stall   sample
//  out      from block out_valid / out_stall filtered
//  cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample is taken per cycle while in_stall is low; its result passes through
// the input register, then the filter logic into the result queue.
// The three-entry result queue sets throughput under output stalls: in_stall
// rises once the queue plus the input register hold three transactions.
// Reset clears the window state and held value and loads the register defaults.
// Configuration writes are always ready and take effect on the next sample.
module battery_voltage_peak_hold_filter_core
    import bvph_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SAMPLE_BITS-1:0]    filtered,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    bvph_cfg_t              cfg_reg;
    bvph_core_status_t      core_status;
    bvph_queue_status_t     queue_status;
    logic [SAMPLE_BITS-1:0] core_result;
    logic                   in_accept;
    logic [QUEUE_COUNT_BITS:0] occupancy;

    // Hold configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length    <= WINDOW_LENGTH_RESET;
            cfg_reg.peak_min_repeats <= PEAK_MIN_REPEATS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH:    cfg_reg.window_length    <= cfg_data;
                CFG_PEAK_MIN_REPEATS: cfg_reg.peak_min_repeats <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Stall input when every queue slot is spoken for
    assign occupancy = {1'b0, queue_status.count}
                     + (QUEUE_COUNT_BITS + 1)'(core_status.stage_valid);
    assign in_stall  = (occupancy >= (QUEUE_COUNT_BITS + 1)'(QUEUE_DEPTH));
    assign in_accept = in_valid && !in_stall;

    bvph_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .sample (sample),
        .cfg    (cfg_reg),
        .status (core_status),
        .result (core_result)
    );

    bvph_queue #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_status.push),
        .push_data (core_result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (filtered),
        .status    (queue_status)
    );

    // An accepted transaction reaches the filter stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> core_status.stage_valid)
        else $error("accepted sample did not reach the filter stage");

    // The queue is never pushed while full without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        core_status.push |->
            (queue_status.count != QUEUE_COUNT_BITS'(QUEUE_DEPTH)) || queue_status.pop)
        else $error("result queue overflow");

    // Queue count rises by one on a push without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (core_status.push && !queue_status.pop) |=>
            (queue_status.count == $past(queue_status.count) + QUEUE_COUNT_BITS'(1)))
        else $error("result queue count did not advance on push");

    // No transaction taken while the stage and queue are full
    assert property (@(posedge clk) disable iff (!rst_n)
        (occupancy >= (QUEUE_COUNT_BITS + 1)'(QUEUE_DEPTH)) |-> !in_accept)
        else $error("sample accepted without queue space");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the battery voltage peak-hold filter top level.
// Needs bvph_pkg and battery_voltage_peak_hold_filter_core; predicts every result internally.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bvph_pkg::*;

    localparam int SB = SAMPLE_BITS_DEFAULT;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [SB-1:0]             sample    = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [SB-1:0]             filtered;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_WINDOW_LENGTH;
    logic [CFG_BITS-1:0]       cfg_data  = '0;

    // Register copies and window state of the predictor
    logic [CFG_BITS-1:0]   win_len    = WINDOW_LENGTH_RESET;
    logic [CFG_BITS-1:0]   min_rep    = PEAK_MIN_REPEATS_RESET;
    logic [COUNT_BITS-1:0] tick_cnt   = '0;
    logic [SB-1:0]         peak_val   = '0;
    logic [SB-1:0]         second_val = '0;
    logic [COUNT_BITS-1:0] peak_rep   = '0;
    logic [SB-1:0]         held_val   = '0;

    logic [SB-1:0] expected_filtered[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_idle_pct  = 0;
    int            hold_off_req   = 0;

    battery_voltage_peak_hold_filter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Run the clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the window by one sample and return the filtered value
    function automatic logic [SB-1:0] filter_step(input logic [SB-1:0] s);
        if (tick_cnt < win_len)
        begin
            tick_cnt = tick_cnt + COUNT_BITS'(1);
            if (s > peak_val)
            begin
                second_val = peak_val;
                peak_val   = s;
                peak_rep   = '0;
            end
            else if (s == peak_val && peak_rep != REPEAT_MAX)
            begin
                peak_rep = peak_rep + COUNT_BITS'(1);
            end
        end
        else
        begin
            // Decision tick: pick the held value, then restart the window
            if (peak_rep >= min_rep)
                held_val = peak_val;
            else if (second_val != '0)
                held_val = second_val;
            tick_cnt   = '0;
            peak_val   = '0;
            second_val = '0;
            peak_rep   = '0;
        end
        return (held_val != '0) ? held_val : s;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Predict on every accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_filtered.push_back(filter_step(sample));
    end

    // Check every accepted output transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_filtered.size() == 0)
                report_mismatch($sformatf("unexpected result filtered=%h", filtered));
            else
            begin
                if (filtered !== expected_filtered[0])
                    report_mismatch($sformatf("filtered=%h, want %h",
                                              filtered, expected_filtered[0]));
                void'(expected_filtered.pop_front());
            end
        end
    end

    // Drive output stall: random idling, or a counted hold-off when requested
    initial
    begin : out_side
        int left;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0 && hold_off_req != 0)
            begin
                left         = hold_off_req;
                hold_off_req = 0;
            end
            if (left > 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else
                out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Offer one sample, with random idle cycles ahead of it; keep valid high afterwards
    task automatic send_sample(input logic [SB-1:0] value);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input logic [CFG_BITS-1:0] window,
                              input logic [CFG_BITS-1:0] repeats);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_data  <= window;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_PEAK_MIN_REPEATS;
        cfg_data  <= repeats;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len = window;
        min_rep = repeats;
    endtask

    // Mostly samples near a level so peaks recur, plus noise and the extremes
    function automatic logic [SB-1:0] pick_sample(input logic [SB-1:0] level);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return level + SB'($urandom_range(3, 0));
        else if (r < 85)
            return SB'($urandom_range(16'hFFFF, 0));
        else if (r < 95)
            return '0;
        else
            return '1;
    endfunction

    // Peak reported, a zero runner-up keeping the held value, a zero peak releasing it
    task automatic test_directed_windows();
        set_config(16'd4, 16'd2);
        send_sample(16'd100);
        send_sample(16'd200);
        send_sample(16'd200);
        send_sample(16'd200);
        send_sample(16'd7);
        send_sample(16'd300);
        send_sample(16'd50);
        send_sample(16'd300);
        send_sample(16'd10);
        send_sample(16'd9);
        repeat (4) send_sample(16'd0);
        send_sample(16'h1357);
        send_sample(16'hFFFF);
        send_sample(16'd1);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
    endtask

    // Zero window: every tick decides; zero repeats then copies a zero peak
    task automatic test_zero_window();
        set_config(16'd0, 16'd2);
        send_sample(16'h8001);
        send_sample(16'h7FFE);
        set_config(16'd0, 16'd0);
        send_sample(16'h1234);
        send_sample(16'hA5A5);
        send_sample(16'h5A5A);
    endtask

    // Random windows and thresholds, each segment with its own sample level
    task automatic test_random_windows(input int n_items);
        int            done;
        int            seg;
        int unsigned   r;
        logic [CFG_BITS-1:0] window;
        logic [CFG_BITS-1:0] repeats;
        logic [SB-1:0] level;
        done = 0;
        while (done < n_items)
        begin
            r = $urandom_range(99, 0);
            if (r < 5)
                window = '0;
            else if (r < 10)
                window = CFG_BITS'($urandom_range(300, 13));
            else
                window = CFG_BITS'($urandom_range(12, 1));
            r = $urandom_range(99, 0);
            if (r < 10)
                repeats = '0;
            else if (r < 15)
                repeats = '1;
            else if (r < 20)
                repeats = CFG_BITS'($urandom_range(16'hFFFF, 0));
            else
                repeats = CFG_BITS'($urandom_range(5, 1));
            set_config(window, repeats);
            level = SB'($urandom_range(16'hFFFF, 0));
            seg   = $urandom_range(60, 20);
            repeat (seg)
            begin
                send_sample(pick_sample(level));
                done++;
            end
        end
    endtask

    // Largest window and threshold: a long run of zeros counts repeats without deciding
    task automatic test_repeat_limit();
        set_config(16'd0, 16'd0);
        send_sample(16'h4321);
        set_config(16'hFFFF, 16'hFFFF);
        repeat (60) send_sample(16'd0);
        send_sample(16'hBEEF);
        send_sample(16'h0042);
    endtask

    // Hold the output off long enough for the block to stall its input
    task automatic test_output_hold_off();
        int i;
        set_config(16'd5, 16'd1);
        hold_off_req = 200;
        for (i = 0; i < 40; i++)
            send_sample(pick_sample(16'h9C40));
    endtask

    initial
    begin : main_seq
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 63;
        test_directed_windows();
        test_zero_window();
        test_random_windows(400);

        send_idle_pct = 63;
        recv_idle_pct = 27;
        test_random_windows(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_windows(400);
        test_repeat_limit();
        test_output_hold_off();

        wait_idle();
        repeat (8) @(posedge clk);
        if (expected_filtered.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_filtered.size()));

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // End a hung run
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== battery_voltage_peak_hold_filter_core.f =====
src/bvph_pkg.sv
src/bvph_core.sv
src/bvph_queue.sv
src/battery_voltage_peak_hold_filter_core.sv
tb/sv/tb.sv
